// ===== hdl/swsc_pkg.sv =====
// shared types and constants for the sliding window coherence core
package swsc_pkg;

  localparam int BinCount   = 1024;
  localparam int DepthMax   = 64;
  localparam int SampleBits = 16;
  localparam int BinBits    = 10;
  localparam int SlotBits   = 6;
  localparam int HistAddrBits = BinBits + SlotBits;
  localparam int PowBits    = 2 * SampleBits;
  localparam int CrossBits  = 2 * SampleBits + 1;
  localparam int PowSumBits = PowBits + SlotBits;
  localparam int CrossSumBits = CrossBits + SlotBits;
  localparam int HalfBits   = PowSumBits / 2;
  localparam int ProdBits   = 2 * PowSumBits;
  localparam int DivSteps   = 32;
  localparam int SqrtSteps  = 16;
  localparam logic [16:0] CohOne = 17'd65536;

  typedef logic signed [SampleBits-1:0] sample_t;

  typedef struct packed {
    logic [PowBits-1:0]   pr;
    logic [PowBits-1:0]   pm;
    logic [CrossBits-1:0] cre;
    logic [CrossBits-1:0] cim;
  } hist_word_t;

  typedef struct packed {
    logic [PowSumBits-1:0]   rr;
    logic [PowSumBits-1:0]   mm;
    logic [CrossSumBits-1:0] cre;
    logic [CrossSumBits-1:0] cim;
  } sum_word_t;

  typedef struct packed {
    logic                    start;
    logic [PowSumBits-1:0]   rr;
    logic [PowSumBits-1:0]   mm;
    logic [CrossSumBits-1:0] cre;
    logic [CrossSumBits-1:0] cim;
  } coh_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] coh;
    logic        zero;
  } coh_rsp_t;

endpackage

// ===== hdl/swsc_coh_unit.sv =====
// iterative coherence unit: shared multiplier, restoring divider, integer root
module swsc_coh_unit
  import swsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  coh_req_t req,
  output coh_rsp_t rsp
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_M1   = 7'b0000010,
    S_M2   = 7'b0000100,
    S_M3   = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_SQRT = 7'b1000000
  } state_t;

  state_t state;
  logic [5:0] step;
  logic half;
  logic [CrossSumBits-2:0] mag_re, mag_im;
  logic [PowSumBits-1:0] rr, mm;
  logic [ProdBits:0] num, den, rem;
  logic [31:0] q;
  logic [31:0] sx;
  logic [16:0] root;
  logic [33:0] sr;
  logic [ProdBits-1:0] prod;
  logic [PowSumBits-1:0] ma, mbf;
  logic [HalfBits-1:0] mb;
  logic [PowSumBits+HalfBits-1:0] part;
  logic [ProdBits:0] rem_sh;
  logic [33:0] sr_sh, trial;

  // one shared multiplier, each product taken in two halves
  always_comb begin
    unique case (state)
      S_M1:    begin ma = mag_re[PowSumBits-1:0]; mbf = mag_re[PowSumBits-1:0]; end
      S_M2:    begin ma = mag_im[PowSumBits-1:0]; mbf = mag_im[PowSumBits-1:0]; end
      default: begin ma = rr; mbf = mm; end
    endcase
    mb = half ? mbf[PowSumBits-1:HalfBits] : mbf[HalfBits-1:0];
    part = ma * mb;
    prod = half ? {part, {HalfBits{1'b0}}} : {{HalfBits{1'b0}}, part};
    rem_sh = {rem[ProdBits-1:0], 1'b0};
    sr_sh  = {sr[31:0], sx[31:30]};
    trial  = {root[15:0], 2'b01};
  end

  function automatic logic [CrossSumBits-2:0] magf(input logic [CrossSumBits-1:0] v);
    logic [CrossSumBits-1:0] n;
    n = v[CrossSumBits-1] ? -v : v;
    return n[CrossSumBits-2:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      half <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        S_IDLE: if (req.start) begin
          rr <= req.rr;
          mm <= req.mm;
          mag_re <= magf(req.cre);
          mag_im <= magf(req.cim);
          half <= 1'b0;
          if (req.rr == '0 || req.mm == '0) begin
            rsp.done <= 1'b1;
            rsp.coh  <= '0;
            rsp.zero <= 1'b1;
          end else begin
            state <= S_M1;
          end
        end
        S_M1: begin
          half <= !half;
          if (!half) begin
            num <= {1'b0, prod};
          end else begin
            num <= num + {1'b0, prod};
            state <= S_M2;
          end
        end
        S_M2: begin
          half <= !half;
          num <= num + {1'b0, prod};
          if (half) state <= S_M3;
        end
        S_M3: begin
          half <= !half;
          if (!half) begin
            den <= {1'b0, prod};
          end else begin
            den <= den + {1'b0, prod};
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (num >= den) begin
            rsp.done <= 1'b1;
            rsp.coh  <= CohOne;
            rsp.zero <= 1'b0;
            state <= S_IDLE;
          end else begin
            rem <= num;
            q <= '0;
            step <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= den) begin
            rem <= rem_sh - den;
            q <= {q[30:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q <= {q[30:0], 1'b0};
          end
          if (step == 6'(DivSteps - 1)) begin
            step <= '0;
            sx <= (rem_sh >= den) ? {q[30:0], 1'b1} : {q[30:0], 1'b0};
            sr <= '0;
            root <= '0;
            state <= S_SQRT;
          end else begin
            step <= step + 6'd1;
          end
        end
        S_SQRT: begin
          sx <= {sx[29:0], 2'b00};
          if (sr_sh >= trial) begin
            sr <= sr_sh - trial;
            root <= {root[15:0], 1'b1};
          end else begin
            sr <= sr_sh;
            root <= {root[15:0], 1'b0};
          end
          if (step == 6'(SqrtSteps - 1)) begin
            rsp.done <= 1'b1;
            rsp.coh  <= (sr_sh >= trial) ? {root[15:0], 1'b1} : {root[15:0], 1'b0};
            rsp.zero <= 1'b0;
            state <= S_IDLE;
          end else begin
            step <= step + 6'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_full_scale: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> rsp.coh <= CohOne) else $error("coherence above one");
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.done && rsp.zero |-> rsp.coh == '0) else $error("zero flag with value");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == S_IDLE)
    else $error("start while busy");
`endif

endmodule

// ===== hdl/sliding_window_spectral_coherence_core.sv =====
// Sliding window magnitude coherence core: one frequency bin per item, 1024 bins,
// history of up to 64 frames per bin in on-chip memories. An accepted item passes
// through the history update (products, memory read, sum update), a hand-over of the
// sums, then the shared coherence unit: three products on one multiplier in two
// halves each, one compare, 32 divide steps and 16 root steps. Zero-power results
// leave the unit before the multiplier, and full-scale results after the compare.
// The next item is taken only once the result is taken; in_ready rises in the cycle
// after. After reset and after every window_depth write a clearing pass over all
// history and sum words runs before items are taken.
module sliding_window_spectral_coherence_core
  import swsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BinBits-1:0]  bin_index,
  input  sample_t             ref_re,
  input  sample_t             ref_im,
  input  sample_t             meas_re,
  input  sample_t             meas_im,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BinBits-1:0]  bin_out,
  output logic [16:0]         coherence_q16,
  output logic                zero_power
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_UPD   = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_PROD  = 7'b1000000
  } state_t;

  state_t state;
  logic [SlotBits:0] depth;
  logic [SlotBits-1:0] slot;
  logic [HistAddrBits:0] clr_cnt;
  logic [BinBits-1:0] bin_r;
  sample_t rre, rim, mre, mim;
  hist_word_t hist_mem [2**HistAddrBits];
  sum_word_t  sum_mem  [2**BinBits];
  hist_word_t hist_rd, hist_new;
  sum_word_t  sum_rd, sum_new;
  logic [HistAddrBits-1:0] hist_addr;
  logic [HistAddrBits-1:0] hist_raddr;
  logic [BinBits-1:0] sum_raddr;
  logic hist_we, sum_we;
  logic [HistAddrBits-1:0] hist_waddr;
  logic [BinBits-1:0] sum_waddr;
  coh_req_t req;
  coh_rsp_t rsp;
  logic [SlotBits-1:0] slot_adv;
  logic [SlotBits:0] slot_inc;
  logic [6:0] depth_w;

  always_comb begin
    slot_inc = {1'b0, slot} + 1'b1;
    slot_adv = (slot_inc >= depth) ? '0 : slot_inc[SlotBits-1:0];
    depth_w = (cfg_wdata == '0) ? 7'd1 : ((cfg_wdata > 7'(DepthMax)) ? 7'(DepthMax) : cfg_wdata);
    hist_addr = {bin_index, (bin_index == '0) ? slot_adv : slot};
    // hold the read address of the item in flight
    hist_raddr = (state == S_IDLE) ? hist_addr : hist_waddr;
    sum_raddr = (state == S_IDLE) ? bin_index : sum_waddr;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_new;
    hist_rd <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_new;
    sum_rd <= sum_mem[sum_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      depth <= 7'd1;
      slot <= '0;
      clr_cnt <= '0;
      hist_we <= 1'b0;
      sum_we <= 1'b0;
      req.start <= 1'b0;
    end else begin
      hist_we <= 1'b0;
      sum_we <= 1'b0;
      req.start <= 1'b0;
      if (cfg_we) begin
        depth <= depth_w;
        slot <= '0;
        clr_cnt <= '0;
        state <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            hist_we <= 1'b1;
            sum_we <= clr_cnt < (HistAddrBits+1)'(BinCount);
            hist_waddr <= clr_cnt[HistAddrBits-1:0];
            sum_waddr <= clr_cnt[BinBits-1:0];
            hist_new <= '0;
            sum_new <= '0;
            clr_cnt <= clr_cnt + 1'b1;
            if (clr_cnt == (HistAddrBits+1)'(2**HistAddrBits - 1)) state <= S_IDLE;
          end
          S_IDLE: if (in_valid) begin
            bin_r <= bin_index;
            rre <= ref_re; rim <= ref_im; mre <= meas_re; mim <= meas_im;
            if (bin_index == '0) slot <= slot_adv;
            hist_waddr <= hist_addr;
            sum_waddr <= bin_index;
            state <= S_PROD;
          end
          S_PROD: begin
            hist_new.pr  <= PowBits'(rre * rre + rim * rim);
            hist_new.pm  <= PowBits'(mre * mre + mim * mim);
            hist_new.cre <= CrossBits'(34'(rre * mre) + 34'(rim * mim));
            hist_new.cim <= CrossBits'(34'(rre * mim) - 34'(rim * mre));
            state <= S_READ;
          end
          S_READ: begin
            sum_new.rr  <= sum_rd.rr - PowSumBits'(hist_rd.pr) + PowSumBits'(hist_new.pr);
            sum_new.mm  <= sum_rd.mm - PowSumBits'(hist_rd.pm) + PowSumBits'(hist_new.pm);
            sum_new.cre <= sum_rd.cre - CrossSumBits'(signed'(hist_rd.cre))
                           + CrossSumBits'(signed'(hist_new.cre));
            sum_new.cim <= sum_rd.cim - CrossSumBits'(signed'(hist_rd.cim))
                           + CrossSumBits'(signed'(hist_new.cim));
            state <= S_UPD;
          end
          S_UPD: begin
            hist_we <= 1'b1;
            sum_we <= 1'b1;
            req.start <= 1'b1;
            req.rr <= sum_new.rr;
            req.mm <= sum_new.mm;
            req.cre <= sum_new.cre;
            req.cim <= sum_new.cim;
            state <= S_WAIT;
          end
          S_WAIT: if (rsp.done) begin
            bin_out <= bin_r;
            coherence_q16 <= rsp.coh;
            zero_power <= rsp.zero;
            state <= S_OUT;
          end
          S_OUT: if (out_ready) state <= S_IDLE;
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  swsc_coh_unit u_coh (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

`ifndef ASSERT_OFF
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    state != S_CLEAR |-> {1'b0, slot} < depth) else $error("slot beyond depth");
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth != '0 && depth <= 7'(DepthMax)) else $error("depth out of range");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(rsp.done)) else $error("result without unit done");
`endif

endmodule

// ===== dv/tb_top.sv =====
// testbench for the sliding window coherence core: scoreboard class and drivers
`timescale 1ns / 1ps

module tb_top;
  import swsc_pkg::*;

  typedef struct {
    logic [BinBits-1:0] bin;
    logic [16:0]        coh;
    logic               zero;
  } coh_result_t;

  class coherence_board;
    int errors;
    int unsigned depth;
    int unsigned slot;
    longint hist_rr[BinCount*DepthMax];
    longint hist_mm[BinCount*DepthMax];
    longint hist_re[BinCount*DepthMax];
    longint hist_im[BinCount*DepthMax];
    longint sum_rr[BinCount];
    longint sum_mm[BinCount];
    longint sum_re[BinCount];
    longint sum_im[BinCount];
    coh_result_t pending[$];

    function new();
      errors = 0;
      set_depth(1);
    endfunction

    function void set_depth(logic [6:0] v);
      depth = (v == 0) ? 1 : ((v > DepthMax) ? DepthMax : v);
      slot = 0;
      hist_rr = '{default: 0};
      hist_mm = '{default: 0};
      hist_re = '{default: 0};
      hist_im = '{default: 0};
      sum_rr = '{default: 0};
      sum_mm = '{default: 0};
      sum_re = '{default: 0};
      sum_im = '{default: 0};
    endfunction

    function void note_input(logic [BinBits-1:0] b, sample_t rr, sample_t ri,
                             sample_t mr, sample_t mi);
      longint pr, pm, cre, cim, are, aim;
      int idx;
      logic [127:0] num, den, q;
      logic [31:0] root, t;
      coh_result_t r;
      r.bin = b;
      r.coh = 0;
      r.zero = 1;
      if (b == 0) begin
        slot++;
        if (slot >= depth) slot = 0;
      end
      pr = longint'(rr) * rr + longint'(ri) * ri;
      pm = longint'(mr) * mr + longint'(mi) * mi;
      cre = longint'(rr) * mr + longint'(ri) * mi;
      cim = longint'(rr) * mi - longint'(ri) * mr;
      idx = b * DepthMax + slot;
      sum_rr[b] += pr - hist_rr[idx];
      sum_mm[b] += pm - hist_mm[idx];
      sum_re[b] += cre - hist_re[idx];
      sum_im[b] += cim - hist_im[idx];
      hist_rr[idx] = pr;
      hist_mm[idx] = pm;
      hist_re[idx] = cre;
      hist_im[idx] = cim;
      if (sum_rr[b] != 0 && sum_mm[b] != 0) begin
        r.zero = 0;
        are = (sum_re[b] < 0) ? -sum_re[b] : sum_re[b];
        aim = (sum_im[b] < 0) ? -sum_im[b] : sum_im[b];
        num = 128'(are) * 128'(are) + 128'(aim) * 128'(aim);
        den = 128'(sum_rr[b]) * 128'(sum_mm[b]);
        if (num >= den) begin
          r.coh = CohOne;
        end else begin
          q = (num << 32) / den;
          root = 0;
          for (int i = 15; i >= 0; i--) begin
            t = root | (32'd1 << i);
            if (64'(t) * 64'(t) <= q) root = t;
          end
          r.coh = root[16:0];
        end
      end
      pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [BinBits-1:0] b, logic [16:0] c, logic z);
      coh_result_t e;
      if (pending.size() == 0) begin
        report("unexpected item, bin", b, -1);
        return;
      end
      e = pending.pop_front();
      if (b !== e.bin) report("bin_out", b, e.bin);
      if (c !== e.coh) report("coherence_q16", c, e.coh);
      if (z !== e.zero) report("zero_power", z, e.zero);
    endtask
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [6:0] cfg_wdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [BinBits-1:0] bin_index, bin_out;
  sample_t ref_re, ref_im, meas_re, meas_im;
  logic [16:0] coherence_q16;
  logic zero_power;

  coherence_board board = new();
  bit quiet = 0;
  bit hold_now = 0;
  int stall_cycles = 0;

  sliding_window_spectral_coherence_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .bin_index(bin_index),
    .ref_re(ref_re), .ref_im(ref_im), .meas_re(meas_re), .meas_im(meas_im),
    .out_valid(out_valid), .out_ready(out_ready), .bin_out(bin_out),
    .coherence_q16(coherence_q16), .zero_power(zero_power)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_input(bin_index, ref_re, ref_im, meas_re, meas_im);
      if (out_valid && out_ready) board.check_result(bin_out, coherence_q16, zero_power);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 200000) begin
        $display("[sliding_window_spectral_coherence_core] ERROR");
        $finish;
      end
    end
  end

  // receiver side
  initial begin
    out_ready <= 0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 0;
        out_ready <= 0;
        repeat (800) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 18);
      end
    end
  end

  task send_item(logic [BinBits-1:0] b, sample_t rr, sample_t ri, sample_t mr, sample_t mi);
    if (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    bin_index <= b;
    ref_re <= rr;
    ref_im <= ri;
    meas_re <= mr;
    meas_im <= mi;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task write_depth(logic [6:0] v);
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    board.set_depth(v);
    cfg_we <= 0;
  endtask

  task send_frames(int count);
    int frame_bins, mode;
    sample_t rr, ri, mr, mi;
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_item(BinBits'($urandom_range(1023)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
        sent++;
      end else begin
        frame_bins = $urandom_range(1, 8);
        for (int b = 0; b < frame_bins; b++) begin
          mode = $urandom_range(4);
          rr = 16'($urandom);
          ri = 16'($urandom);
          case (mode)
            0: begin
              mr = 16'($urandom);
              mi = 16'($urandom);
            end
            1: begin
              mr = (rr >>> $urandom_range(0, 4)) + $signed(5'($urandom));
              mi = (ri >>> $urandom_range(0, 4)) + $signed(5'($urandom));
            end
            2: begin
              rr = 16'($signed(8'($urandom)));
              ri = 16'($signed(8'($urandom)));
              mr = 16'($signed(8'($urandom)));
              mi = 16'($signed(8'($urandom)));
            end
            3: begin
              mr = rr;
              mi = ri;
            end
            default: begin
              mr = '0;
              mi = '0;
            end
          endcase
          send_item(BinBits'(b), rr, ri, mr, mi);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst <= 1;
    cfg_we <= 0;
    cfg_wdata <= 0;
    in_valid <= 0;
    bin_index <= 0;
    ref_re <= 0;
    ref_im <= 0;
    meas_re <= 0;
    meas_im <= 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed items at reset depth
    send_item(0, 0, 0, 0, 0);
    send_item(1, 100, -50, 0, 0);
    send_item(2, 0, 0, 7, 9);
    send_item(3, 32767, 32767, 32767, 32767);
    send_item(4, -32768, -32768, -32768, -32768);
    send_item(5, -32768, 32767, 32767, -32768);
    send_item(1023, 32767, -32768, -32768, 32767);
    send_item(0, 1, 0, 0, 1);
    send_item(6, 1000, 2000, 2000, -1000);
    send_item(7, 3, 4, 5, 6);
    send_item(1023, 0, 0, 0, 0);
    send_item(512, -1, -1, 1, 1);

    write_depth(7'd0);
    send_frames(200);
    write_depth(7'd64);
    send_frames(10);
    hold_now = 1;
    send_frames(290);
    write_depth(7'd127);
    quiet = 1;
    send_frames(300);
    quiet = 0;
    write_depth(7'd5);
    send_items_mixed: begin
      send_frames(300);
    end
    write_depth(7'd1);
    send_frames(200);
    write_depth(7'd3);
    send_frames(300);
    in_valid <= 0;
    @(posedge clk);

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("[sliding_window_spectral_coherence_core] OK");
    end else begin
      $display("[sliding_window_spectral_coherence_core] ERROR");
    end
    $finish;
  end

endmodule
